// File: design/scf_pkg.sv
// Shared types and constants of the syscall filter policy table.
package scf_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int PID_W   = 32;
    localparam int NR_W    = 32;
    localparam int WORD_W  = 32;
    localparam int PROG_W  = 8;
    localparam int ERRNO_W = 16;

    typedef enum logic [1:0] {
        CMD_SET     = 2'd0,
        CMD_CHECK   = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_RESOLVE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_DISABLED = 2'd0,
        MODE_STRICT   = 2'd1,
        MODE_FILTER   = 2'd2,
        MODE_UNKNOWN  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        VERDICT_ALLOW = 2'd0,
        VERDICT_KILL  = 2'd1,
        VERDICT_ERRNO = 2'd2,
        VERDICT_RUN   = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [PID_W-1:0]  pid;
        mode_t             mode;
        logic [PROG_W-1:0] prog;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Syscalls that strict mode lets through
    localparam logic [NR_W-1:0] NR_READ       = 32'd0;
    localparam logic [NR_W-1:0] NR_WRITE      = 32'd1;
    localparam logic [NR_W-1:0] NR_RT_SIGRET  = 32'd15;
    localparam logic [NR_W-1:0] NR_EXIT       = 32'd60;
    localparam logic [NR_W-1:0] NR_EXIT_GROUP = 32'd231;

    // Filter program return actions
    localparam logic [WORD_W-1:0] ACT_MASK  = 32'hFFFF_0000;
    localparam logic [WORD_W-1:0] ACT_ALLOW = 32'h7FFF_0000;
    localparam logic [WORD_W-1:0] ACT_KILL  = 32'h0000_0000;
    localparam logic [WORD_W-1:0] ACT_ERRNO = 32'h0005_0000;

    function automatic logic strict_allowed(input logic [NR_W-1:0] nr);
        return (nr == NR_READ) || (nr == NR_WRITE) || (nr == NR_RT_SIGRET) ||
               (nr == NR_EXIT) || (nr == NR_EXIT_GROUP);
    endfunction

endpackage

// File: design/scf_if.sv
// Request and response channel interfaces of the syscall filter policy table.
interface scf_req_if
    import scf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [PID_W-1:0]  process_id;
    logic [1:0]        new_mode;
    logic [PROG_W-1:0] program_index;
    logic [NR_W-1:0]   syscall_number;
    logic [WORD_W-1:0] filter_return;

    modport source (output valid, cmd, process_id, new_mode, program_index,
                    syscall_number, filter_return, input ready);
    modport sink   (input valid, cmd, process_id, new_mode, program_index,
                    syscall_number, filter_return, output ready);
endinterface

interface scf_rsp_if
    import scf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               set_status;
    logic [1:0]         verdict;
    logic [ERRNO_W-1:0] errno_value;
    logic [PROG_W-1:0]  filter_program;

    modport source (output valid, set_status, verdict, errno_value, filter_program,
                    input ready);
    modport sink   (input valid, set_status, verdict, errno_value, filter_program,
                    output ready);
endinterface

// File: design/scf_ram.sv
// Generic simple dual-port RAM with registered read.
module scf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// File: design/syscall_filter_policy_table.sv
// Top level of the syscall filter policy table.
//
// Per-process syscall policy table in the style of seccomp. Each request
// transfer carries one command; each command gives exactly one response
// transfer. Set, check and clear walk the table one entry per cycle through a
// single compare unit fed by the table RAM's registered read port: clear
// visits every entry; set stops at an active entry with the same id, check
// at the first entry whose id matches; else each walks on to the last entry.
// Resolve needs no walk and goes straight from the request to the result.
// The request side is ready only while no command is in work; a finished
// response sits in an output register so the next request may transfer while
// it waits. Entries read as all zero (id 0, disabled) until first written;
// one valid flop per entry gives this, so no clearing pass follows reset.
// The engine-present flag resets to 1 and is written through cfg_wr_en and
// cfg_wr_data; the user writes it only while the block is idle (unchecked).
module syscall_filter_policy_table
    import scf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    scf_req_if.sink   req,
    scf_rsp_if.source rsp
);

    // Sequencer and command registers
    state_t             state_reg, state_next;
    cmd_t               op_cmd_reg, op_cmd_next;
    logic [PID_W-1:0]   op_pid_reg, op_pid_next;
    mode_t              op_mode_reg, op_mode_next;
    logic [PROG_W-1:0]  op_prog_reg, op_prog_next;
    logic [NR_W-1:0]    op_nr_reg, op_nr_next;

    // Walk state
    logic [CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               have_free_reg, have_free_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;

    // Result held until the output register is free
    logic               res_status_reg, res_status_next;
    verdict_t           res_verdict_reg, res_verdict_next;
    logic [ERRNO_W-1:0] res_errno_reg, res_errno_next;
    logic [PROG_W-1:0]  res_prog_reg, res_prog_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic               out_status_reg, out_status_next;
    verdict_t           out_verdict_reg, out_verdict_next;
    logic [ERRNO_W-1:0] out_errno_reg, out_errno_next;
    logic [PROG_W-1:0]  out_prog_reg, out_prog_next;

    logic                     engine_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    // Table RAM ports
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_rdata;

    logic             req_xfer;
    logic             rsp_free;
    logic             scan_done;
    entry_t           ent;
    logic             id_hit;
    logic             last_entry;
    logic [WORD_W-1:0] action;

    scf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign rsp_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid          = out_valid_reg;
    assign rsp.set_status     = out_status_reg;
    assign rsp.verdict        = out_verdict_reg;
    assign rsp.errno_value    = out_errno_reg;
    assign rsp.filter_program = out_prog_reg;

    // An entry never written reads as id 0, disabled, program 0
    assign ent        = valid_reg[pend_idx_reg] ? ram_rdata : '0;
    assign id_hit     = (ent.pid == op_pid_reg);
    assign last_entry = (pend_idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign action     = req.filter_return & ACT_MASK;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = (cmd_t'(req.cmd) == CMD_RESOLVE) ? ST_RESULT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        op_cmd_next      = op_cmd_reg;
        op_pid_next      = op_pid_reg;
        op_mode_next     = op_mode_reg;
        op_prog_next     = op_prog_reg;
        op_nr_next       = op_nr_reg;
        rd_cnt_next      = rd_cnt_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        have_free_next   = have_free_reg;
        free_idx_next    = free_idx_reg;
        res_status_next  = res_status_reg;
        res_verdict_next = res_verdict_reg;
        res_errno_next   = res_errno_reg;
        res_prog_next    = res_prog_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_verdict_next = out_verdict_reg;
        out_errno_next   = out_errno_reg;
        out_prog_next    = out_prog_reg;
        valid_next       = valid_reg;
        ram_we           = 1'b0;
        ram_waddr        = pend_idx_reg;
        ram_wdata        = '{pid: op_pid_reg, mode: op_mode_reg, prog: op_prog_reg};
        ram_re           = 1'b0;
        ram_raddr        = rd_cnt_reg[IDX_W-1:0];
        scan_done        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    // Capture the command and start with an allow result
                    op_cmd_next      = cmd_t'(req.cmd);
                    op_pid_next      = req.process_id;
                    op_mode_next     = mode_t'(req.new_mode);
                    op_prog_next     = req.program_index;
                    op_nr_next       = req.syscall_number;
                    rd_cnt_next      = '0;
                    pend_next        = 1'b0;
                    have_free_next   = 1'b0;
                    res_status_next  = 1'b0;
                    res_verdict_next = VERDICT_ALLOW;
                    res_errno_next   = '0;
                    res_prog_next    = '0;
                    if (cmd_t'(req.cmd) == CMD_RESOLVE)
                    begin
                        if (action == ACT_KILL)
                        begin
                            res_verdict_next = VERDICT_KILL;
                        end
                        else if (action == ACT_ERRNO &&
                                 req.filter_return[ERRNO_W-1:0] != '0)
                        begin
                            res_verdict_next = VERDICT_ERRNO;
                            res_errno_next   = req.filter_return[ERRNO_W-1:0];
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                // Issue the next table read
                if (rd_cnt_reg < CNT_W'(TABLE_ENTRIES))
                begin
                    ram_re        = 1'b1;
                    rd_cnt_next   = rd_cnt_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = rd_cnt_reg[IDX_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // Judge the entry whose read data just arrived
                if (pend_reg)
                begin
                    case (op_cmd_reg)
                        CMD_SET:
                        begin
                            if (id_hit && ent.mode != MODE_DISABLED)
                            begin
                                ram_we                  = 1'b1;
                                ram_waddr               = pend_idx_reg;
                                valid_next[pend_idx_reg] = 1'b1;
                                scan_done               = 1'b1;
                            end
                            else
                            begin
                                if (ent.mode == MODE_DISABLED && !have_free_reg)
                                begin
                                    have_free_next = 1'b1;
                                    free_idx_next  = pend_idx_reg;
                                end
                                if (last_entry)
                                begin
                                    scan_done = 1'b1;
                                    if (have_free_reg)
                                    begin
                                        ram_we                  = 1'b1;
                                        ram_waddr               = free_idx_reg;
                                        valid_next[free_idx_reg] = 1'b1;
                                    end
                                    else if (ent.mode == MODE_DISABLED)
                                    begin
                                        ram_we                  = 1'b1;
                                        ram_waddr               = pend_idx_reg;
                                        valid_next[pend_idx_reg] = 1'b1;
                                    end
                                    else
                                    begin
                                        res_status_next = 1'b1;
                                    end
                                end
                            end
                        end
                        CMD_CHECK:
                        begin
                            if (id_hit)
                            begin
                                scan_done = 1'b1;
                                case (ent.mode)
                                    MODE_STRICT:
                                    begin
                                        res_verdict_next = strict_allowed(op_nr_reg) ?
                                                           VERDICT_ALLOW : VERDICT_KILL;
                                    end
                                    MODE_FILTER:
                                    begin
                                        if (engine_reg)
                                        begin
                                            res_verdict_next = VERDICT_RUN;
                                            res_prog_next    = ent.prog;
                                        end
                                    end
                                    default:
                                    begin
                                        res_verdict_next = VERDICT_ALLOW;
                                    end
                                endcase
                            end
                            else if (last_entry)
                            begin
                                scan_done = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            // Disable in place; keep id and program
                            if (id_hit && ent.mode != MODE_DISABLED)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = pend_idx_reg;
                                ram_wdata = '{pid: ent.pid, mode: MODE_DISABLED,
                                              prog: ent.prog};
                            end
                            if (last_entry)
                            begin
                                scan_done = 1'b1;
                            end
                        end
                        default:
                        begin
                            scan_done = 1'b1;
                        end
                    endcase
                end

                // Drop any read still in flight
                if (scan_done)
                begin
                    pend_next = 1'b0;
                end
            end
            ST_RESULT:
            begin
                if (rsp_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_verdict_next = res_verdict_reg;
                    out_errno_next   = res_errno_reg;
                    out_prog_next    = res_prog_reg;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase

        // Retire the response on its transfer unless a new one loads
        if (out_valid_reg && rsp.ready && !(state_reg == ST_RESULT))
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
            have_free_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            engine_reg    <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            pend_reg      <= pend_next;
            have_free_reg <= have_free_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            if (cfg_wr_en)
            begin
                engine_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_cmd_reg      <= op_cmd_next;
        op_pid_reg      <= op_pid_next;
        op_mode_reg     <= op_mode_next;
        op_prog_reg     <= op_prog_next;
        op_nr_reg       <= op_nr_next;
        pend_idx_reg    <= pend_idx_next;
        free_idx_reg    <= free_idx_next;
        res_status_reg  <= res_status_next;
        res_verdict_reg <= res_verdict_next;
        res_errno_reg   <= res_errno_next;
        res_prog_reg    <= res_prog_next;
        out_status_reg  <= out_status_next;
        out_verdict_reg <= out_verdict_next;
        out_errno_reg   <= out_errno_next;
        out_prog_reg    <= out_prog_next;
    end

`ifndef SYNTHESIS
    // The table is only written while a walk is in progress
    a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_SCAN))
        else $error("table write outside a walk");

    // A pending read never survives the walk
    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_SCAN))
        else $error("pending table read outside a walk");

    // Entries once written stay valid
    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (($past(valid_reg) & ~valid_reg) == '0))
        else $error("table entry lost its valid bit");

    // Resolve skips the walk
    a_resolve_direct: assert property (@(posedge clk) disable iff (!rst_n)
        (req_xfer && cmd_t'(req.cmd) == CMD_RESOLVE) |=> (state_reg == ST_RESULT))
        else $error("resolve did not go straight to result");

    // A full-table status never comes with a non-allow verdict
    a_full_allow: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.set_status) |->
            (rsp.verdict == VERDICT_ALLOW && rsp.errno_value == '0))
        else $error("set status with a non-allow verdict");
`endif

endmodule

// File: tb/sv/tb_syscall_filter_policy_table.sv
// Self-checking testbench for the syscall filter policy table: directed and random commands.
module tb_syscall_filter_policy_table
    import scf_pkg::*;
();

    // One request transfer, unpacked into the fields that the block sees
    typedef struct {
        cmd_t              cmd;
        logic [PID_W-1:0]  pid;
        mode_t             mode;
        logic [PROG_W-1:0] prog;
        logic [NR_W-1:0]   nr;
        logic [WORD_W-1:0] word;
    } policy_req_t;

    // One response transfer as the table should produce it
    typedef struct {
        logic               status;
        verdict_t           verdict;
        logic [ERRNO_W-1:0] errno_v;
        logic [PROG_W-1:0]  prog;
    } policy_rsp_t;

    localparam int POOL_SIZE   = 8;
    localparam int RANDOM_ITEMS = 520;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    scf_req_if req_ch();
    scf_rsp_if rsp_ch();

    syscall_filter_policy_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the policy table and of the engine-present register
    logic [PID_W-1:0]  tbl_pid  [TABLE_ENTRIES];
    mode_t             tbl_mode [TABLE_ENTRIES];
    logic [PROG_W-1:0] tbl_prog [TABLE_ENTRIES];
    logic              engine_on;

    // Verdicts predicted at request transfer, oldest first
    policy_rsp_t expected_verdicts[$];

    // Process ids that random traffic keeps coming back to, so that set, check
    // and clear keep hitting the same entries
    logic [PID_W-1:0] pid_pool[POOL_SIZE];

    int mismatches    = 0;
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int hold_cycles   = 0;

    // ------------------------------------------------------------------
    // Prediction: apply one command to the shadow table and return the
    // response that it must produce.
    // ------------------------------------------------------------------
    function automatic policy_rsp_t policy_decide(input policy_req_t r);
        policy_rsp_t       o;
        int                i;
        int                slot;
        bit                found;
        logic [WORD_W-1:0] action;
        o.status  = 1'b0;
        o.verdict = VERDICT_ALLOW;
        o.errno_v = '0;
        o.prog    = '0;
        case (r.cmd)
            CMD_SET:
            begin
                // An active entry of this process wins; else the lowest disabled one
                slot = -1;
                for (i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (tbl_pid[i] == r.pid && tbl_mode[i] != MODE_DISABLED)
                    begin
                        slot = i;
                        break;
                    end
                    if (slot < 0 && tbl_mode[i] == MODE_DISABLED)
                        slot = i;
                end
                if (slot < 0)
                    o.status = 1'b1;
                else
                begin
                    tbl_pid[slot]  = r.pid;
                    tbl_mode[slot] = r.mode;
                    tbl_prog[slot] = r.prog;
                end
            end
            CMD_CHECK:
            begin
                // First id match decides, even when that entry is disabled
                found = 1'b0;
                for (i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (!found && tbl_pid[i] == r.pid)
                    begin
                        found = 1'b1;
                        case (tbl_mode[i])
                            MODE_STRICT:
                            begin
                                if (r.nr == NR_READ || r.nr == NR_WRITE ||
                                    r.nr == NR_RT_SIGRET || r.nr == NR_EXIT ||
                                    r.nr == NR_EXIT_GROUP)
                                    o.verdict = VERDICT_ALLOW;
                                else
                                    o.verdict = VERDICT_KILL;
                            end
                            MODE_FILTER:
                            begin
                                if (engine_on)
                                begin
                                    o.verdict = VERDICT_RUN;
                                    o.prog    = tbl_prog[i];
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            CMD_CLEAR:
            begin
                // Disable only; id and program stay behind
                for (i = 0; i < TABLE_ENTRIES; i++)
                    if (tbl_pid[i] == r.pid)
                        tbl_mode[i] = MODE_DISABLED;
            end
            default:
            begin
                action = r.word & ACT_MASK;
                if (action == ACT_KILL)
                    o.verdict = VERDICT_KILL;
                else if (action == ACT_ERRNO && r.word[ERRNO_W-1:0] != '0)
                begin
                    o.verdict = VERDICT_ERRNO;
                    o.errno_v = r.word[ERRNO_W-1:0];
                end
            end
        endcase
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Random field sources, biased toward the values that matter
    // ------------------------------------------------------------------
    function automatic logic [NR_W-1:0] pick_syscall();
        logic [NR_W-1:0] allowed[5];
        allowed = '{NR_READ, NR_WRITE, NR_RT_SIGRET, NR_EXIT, NR_EXIT_GROUP};
        case ($urandom_range(9))
            0, 1, 2: return allowed[$urandom_range(4)];
            3, 4:    return allowed[$urandom_range(4)] + 1;
            5:       return allowed[$urandom_range(4)] - 1;
            6:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_return();
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo;
        case ($urandom_range(5))
            0:       hi = ACT_ALLOW;
            1:       hi = ACT_KILL;
            2, 3:    hi = ACT_ERRNO;
            4:       hi = $urandom;
            default: hi = ACT_MASK;
        endcase
        case ($urandom_range(3))
            0:       lo = '0;
            1:       lo = 32'h0000_FFFF;
            default: lo = $urandom;
        endcase
        return (hi & ACT_MASK) | (lo & ~ACT_MASK);
    endfunction

    function automatic policy_req_t rand_req();
        policy_req_t r;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 30)
            r.cmd = CMD_SET;
        else if (pick < 70)
            r.cmd = CMD_CHECK;
        else if (pick < 80)
            r.cmd = CMD_CLEAR;
        else
            r.cmd = CMD_RESOLVE;
        if ($urandom_range(99) < 85)
            r.pid = pid_pool[$urandom_range(POOL_SIZE-1)];
        else
            r.pid = $urandom;
        r.mode = mode_t'($urandom_range(3));
        r.prog = PROG_W'($urandom_range(255));
        r.nr   = pick_syscall();
        r.word = pick_return();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side: drive at the falling edge, detect the transfer at the
    // rising edge, predict at the transfer. Valid stays high between
    // back-to-back items and drops only for an idle gap or a drain.
    // ------------------------------------------------------------------
    task automatic send_req(input policy_req_t r);
        int gap;
        gap = ($urandom_range(99) < snd_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid          <= 1'b1;
        req_ch.cmd            <= r.cmd;
        req_ch.process_id     <= r.pid;
        req_ch.new_mode       <= r.mode;
        req_ch.program_index  <= r.prog;
        req_ch.syscall_number <= r.nr;
        req_ch.filter_return  <= r.word;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_verdicts.push_back(policy_decide(r));
    endtask

    // Fill unused fields with noise so that the block must ignore them
    task automatic issue_set(input logic [PID_W-1:0] pid, input mode_t m,
                             input logic [PROG_W-1:0] p);
        policy_req_t r;
        r      = rand_req();
        r.cmd  = CMD_SET;
        r.pid  = pid;
        r.mode = m;
        r.prog = p;
        send_req(r);
    endtask

    task automatic issue_check(input logic [PID_W-1:0] pid, input logic [NR_W-1:0] nr);
        policy_req_t r;
        r     = rand_req();
        r.cmd = CMD_CHECK;
        r.pid = pid;
        r.nr  = nr;
        send_req(r);
    endtask

    task automatic issue_clear(input logic [PID_W-1:0] pid);
        policy_req_t r;
        r     = rand_req();
        r.cmd = CMD_CLEAR;
        r.pid = pid;
        send_req(r);
    endtask

    task automatic issue_resolve(input logic [WORD_W-1:0] word);
        policy_req_t r;
        r      = rand_req();
        r.cmd  = CMD_RESOLVE;
        r.word = word;
        send_req(r);
    endtask

    // Drop valid and hold until every predicted verdict has come back
    task automatic wait_all_verdicts();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // Write the engine-present register; the block is idle once drained,
    // since every command answers with exactly one response
    task automatic set_engine(input logic on);
        wait_all_verdicts();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        engine_on    = on;
    endtask

    // ------------------------------------------------------------------
    // Response side: ready is driven at the falling edge. A hold-off
    // counts down here, one cycle at a time, with ready held low.
    // ------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // Compare every response transfer with the oldest prediction
    always @(posedge clk)
    begin : check_rsp
        policy_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: status=%0d verdict=%0d errno=%h prog=%h",
                             rsp_ch.set_status, rsp_ch.verdict, rsp_ch.errno_value,
                             rsp_ch.filter_program);
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (rsp_ch.set_status !== want.status || rsp_ch.verdict !== want.verdict ||
                    rsp_ch.errno_value !== want.errno_v ||
                    rsp_ch.filter_program !== want.prog)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("mismatch: expected status=%0d verdict=%0d errno=%h prog=%h,",
                               want.status, want.verdict, want.errno_v, want.prog);
                        $display(" got status=%0d verdict=%0d errno=%h prog=%h",
                                 rsp_ch.set_status, rsp_ch.verdict, rsp_ch.errno_value,
                                 rsp_ch.filter_program);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every id resets to zero, so process 0 hits disabled entry 0 and is allowed;
    // an id found nowhere is allowed as well
    task automatic test_after_reset();
        issue_check('0, NR_EXIT + 1);
        issue_check('1, 32'd1000);
        issue_clear('0);
    endtask

    // Strict mode: the five permitted syscalls pass, a neighbor and the all-ones number die
    task automatic test_strict_mode();
        issue_set('1, MODE_STRICT, '0);
        issue_check('1, NR_READ);
        issue_check('1, NR_WRITE);
        issue_check('1, NR_RT_SIGRET);
        issue_check('1, NR_EXIT);
        issue_check('1, NR_EXIT_GROUP);
        issue_check('1, NR_WRITE + 1);
        issue_check('1, '1);
    endtask

    // Filter mode asks for a program run only while the engine is present
    task automatic test_filter_mode();
        logic [PID_W-1:0] pid;
        pid = $urandom;
        issue_set(pid, MODE_FILTER, 8'hFF);
        issue_check(pid, $urandom);
        set_engine(1'b0);
        issue_check(pid, $urandom);
        set_engine(1'b1);
        issue_check(pid, $urandom);
    endtask

    // Unknown mode allows; a disabled entry allows and is reused by the next set; clear disables
    task automatic test_other_modes();
        issue_set(32'd1, MODE_UNKNOWN, 8'h5A);
        issue_check(32'd1, NR_WRITE + 1);
        issue_set('1, MODE_DISABLED, 8'h01);
        issue_check('1, NR_WRITE + 1);
        issue_set('1, MODE_STRICT, 8'h02);
        issue_check('1, NR_WRITE + 1);
        issue_clear('1);
        issue_check('1, NR_WRITE + 1);
    endtask

    // Return actions: allow, kill, errno (with errno zero falling back to allow), other
    task automatic test_resolve_actions();
        issue_resolve(ACT_ALLOW | 32'h0000_1234);
        issue_resolve(ACT_KILL);
        issue_resolve(ACT_KILL | 32'h0000_FFFF);
        issue_resolve(ACT_ERRNO);
        issue_resolve(ACT_ERRNO | 32'h0000_FFFF);
        issue_resolve(ACT_ERRNO | 32'h0000_000D);
        issue_resolve(32'h1234_0005);
        issue_resolve('1);
    endtask

    // Fill every free slot with a fresh process, overflow, update in place while
    // full, then release the whole block of ids again
    task automatic test_table_full();
        logic [PID_W-1:0] base;
        int               i;
        base = 32'hC000_0000 | ($urandom & 32'h3FFF_FF00);
        for (i = 0; i < TABLE_ENTRIES; i++)
            issue_set(base + i, (i % 2) ? MODE_STRICT : MODE_FILTER, PROG_W'(i));
        issue_set(base + TABLE_ENTRIES, MODE_STRICT, 8'h11);
        issue_set(base + 2, MODE_UNKNOWN, 8'h22);
        issue_check(base + 2, NR_WRITE + 1);
        issue_check(base + TABLE_ENTRIES, NR_WRITE + 1);
        for (i = 0; i < TABLE_ENTRIES; i++)
            issue_clear(base + i);
    endtask

    // Hold the response side off for a long stretch while requests keep coming,
    // so the output register fills and the request side stalls; then pause the
    // sender until the table has answered everything
    task automatic test_output_backpressure();
        int keep;
        int i;
        keep         = snd_idle_pct;
        snd_idle_pct = 0;
        @(posedge clk);
        hold_cycles = 400;
        for (i = 0; i < 12; i++)
            send_req(rand_req());
        wait_all_verdicts();
        snd_idle_pct = keep;
    endtask

    task automatic test_random_traffic(input int count);
        int i;
        pid_pool[0] = '0;
        pid_pool[1] = '1;
        for (i = 2; i < POOL_SIZE; i++)
            pid_pool[i] = $urandom;
        for (i = 0; i < count; i++)
            send_req(rand_req());
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.cmd            = CMD_SET;
        req_ch.process_id     = '0;
        req_ch.new_mode       = MODE_DISABLED;
        req_ch.program_index  = '0;
        req_ch.syscall_number = '0;
        req_ch.filter_return  = '0;
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            tbl_pid[i]  = '0;
            tbl_mode[i] = MODE_DISABLED;
            tbl_prog[i] = '0;
        end
        for (i = 0; i < POOL_SIZE; i++)
            pid_pool[i] = '0;
        engine_on = 1'b1;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Light sender gaps, heavy receiver stalls
        snd_idle_pct  = 15;
        rcv_stall_pct = 64;
        test_after_reset();
        test_strict_mode();
        test_filter_mode();
        test_other_modes();
        test_resolve_actions();
        test_table_full();
        test_output_backpressure();
        test_random_traffic(RANDOM_ITEMS);

        // Swap the pressure and run filter checks with no engine
        set_engine(1'b0);
        snd_idle_pct  = 64;
        rcv_stall_pct = 15;
        test_random_traffic(RANDOM_ITEMS);

        // Full rate both ways, engine back
        set_engine(1'b1);
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        test_random_traffic(RANDOM_ITEMS);

        // Drain, then let a full table walk go by to catch stray responses
        wait_all_verdicts();
        repeat (TABLE_ENTRIES + 8) @(posedge clk);
        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial
    begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
